[hdl/ulle_pkg.sv]
// shared constants, codes and types of the linked list engine
package ulle_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int POS_W        = 7;
    localparam int VAL_W        = 32;

    localparam logic [3:0] OP_INS_FRONT = 4'd0;
    localparam logic [3:0] OP_INS_BACK  = 4'd1;
    localparam logic [3:0] OP_INS_AFTER = 4'd2;
    localparam logic [3:0] OP_DEL_FRONT = 4'd3;
    localparam logic [3:0] OP_DEL_BACK  = 4'd4;
    localparam logic [3:0] OP_DEL_VALUE = 4'd5;
    localparam logic [3:0] OP_SEARCH    = 4'd6;
    localparam logic [3:0] OP_TRAVERSE  = 4'd7;
    localparam logic [3:0] OP_CLEAR     = 4'd8;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic                    ins;
        logic                    del;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] data;
    } t_edit;

endpackage

[hdl/ulle_if.sv]
// channel interfaces of the linked list engine
interface ulle_in_if;
    logic               valid;
    logic               ready;
    logic [3:0]         operation;
    logic signed [31:0] value;
    logic signed [31:0] key;
    modport source (output valid, operation, value, key, input ready);
    modport sink   (input valid, operation, value, key, output ready);
endinterface

interface ulle_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] result_value;
    logic               last;
    modport source (output valid, status, result_value, last, input ready);
    modport sink   (input valid, status, result_value, last, output ready);
endinterface

[hdl/unordered_linked_list_engine_unit.sv]
// list engine top: control sequencer over a row of element cells
//
//  channel  dir  beat fields
//  i_in     in   operation, value, key
//  o_out    out  status, result_value, last
//
// elements are kept in list order in a row of CAPACITY cells
// front/back ops go straight to the result; search, delete by value and
// insert after scan from the front, one cell per cycle, to the match or list end
// traverse emits the elements in list order; output register frees input side
// synchronous active-low reset empties the list; no clearing pass
module unordered_linked_list_engine_unit #(
    parameter int CAPACITY = ulle_pkg::CAPACITY_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ulle_in_if.sink       i_in,
    ulle_out_if.source    o_out
);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int VW = ulle_pkg::VAL_W;
    localparam int PW = ulle_pkg::POS_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_EMIT = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [3:0]           r_op, n_op;
    logic signed [VW-1:0] r_val, n_val;
    logic signed [VW-1:0] r_key, n_key;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [IW-1:0]        r_j, n_j;
    logic [1:0]           r_status, n_status;
    logic signed [VW-1:0] r_res, n_res;
    logic                 r_ovalid, n_ovalid;
    logic [1:0]           r_ostatus, n_ostatus;
    logic signed [VW-1:0] r_ovalue, n_ovalue;
    logic                 r_olast, n_olast;

    ulle_pkg::t_edit      edit;
    logic signed [VW-1:0] cell_q [CAPACITY];
    logic [CAPACITY-1:0]  match;
    logic signed [VW-1:0] cmp_val;
    logic [IW-1:0]        rd_idx;
    logic signed [VW-1:0] rd_val;
    logic                 slot_free;
    logic                 full;
    logic                 empty;
    logic [IW-1:0]        last_idx;
    logic                 accept;

    assign full      = (r_cnt == CW'(CAPACITY));
    assign empty     = (r_cnt == '0);
    assign last_idx  = IW'(r_cnt - CW'(1));
    assign slot_free = !r_ovalid || o_out.ready;
    assign accept    = i_in.valid && i_in.ready;
    assign cmp_val   = (r_op == ulle_pkg::OP_INS_AFTER) ? r_key : r_val;
    assign rd_idx    = (r_state == S_IDLE && i_in.operation == ulle_pkg::OP_DEL_BACK)
                       ? last_idx : ((r_state == S_IDLE) ? '0 : r_j);
    assign rd_val    = cell_q[rd_idx];

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [VW-1:0] left_v, right_v;
            if (g == 0) begin : g_first
                assign left_v = '0;
            end else begin : g_mid
                assign left_v = cell_q[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign right_v = cell_q[g];
            end else begin : g_inner
                assign right_v = cell_q[g+1];
            end
            ulle_cell #(.IDX(g)) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (edit),
                .i_left  (left_v),
                .i_right (right_v),
                .i_cmp   (cmp_val),
                .o_value (cell_q[g]),
                .o_match (match[g])
            );
        end
    endgenerate

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_val     = r_val;
        n_key     = r_key;
        n_cnt     = r_cnt;
        n_j       = r_j;
        n_status  = r_status;
        n_res     = r_res;
        n_ovalid  = r_ovalid && !o_out.ready;
        n_ostatus = r_ostatus;
        n_ovalue  = r_ovalue;
        n_olast   = r_olast;
        edit      = '{ins: 1'b0, del: 1'b0, pos: '0, data: '0};

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op     = i_in.operation;
                    n_val    = i_in.value;
                    n_key    = i_in.key;
                    n_j      = '0;
                    n_res    = '0;
                    n_status = ulle_pkg::ST_OK;
                    n_state  = S_DONE;
                    case (i_in.operation)
                        ulle_pkg::OP_INS_FRONT, ulle_pkg::OP_INS_BACK: begin
                            if (full) begin
                                n_status = ulle_pkg::ST_FULL;
                            end else begin
                                edit.ins  = 1'b1;
                                edit.pos  = (i_in.operation == ulle_pkg::OP_INS_BACK)
                                            ? PW'(r_cnt) : '0;
                                edit.data = i_in.value;
                                n_cnt     = r_cnt + CW'(1);
                            end
                        end
                        ulle_pkg::OP_INS_AFTER: begin
                            if (full) begin
                                n_status = ulle_pkg::ST_FULL;
                            end else if (empty) begin
                                n_status = ulle_pkg::ST_EMPTY;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        ulle_pkg::OP_DEL_FRONT, ulle_pkg::OP_DEL_BACK: begin
                            if (empty) begin
                                n_status = ulle_pkg::ST_EMPTY;
                            end else begin
                                n_res    = rd_val;
                                edit.del = (i_in.operation == ulle_pkg::OP_DEL_FRONT);
                                n_cnt    = r_cnt - CW'(1);
                            end
                        end
                        ulle_pkg::OP_DEL_VALUE: begin
                            if (empty) begin
                                n_status = ulle_pkg::ST_EMPTY;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        ulle_pkg::OP_SEARCH: begin
                            if (empty) begin
                                n_status = ulle_pkg::ST_NOT_FOUND;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        ulle_pkg::OP_TRAVERSE: begin
                            if (empty) begin
                                n_status = ulle_pkg::ST_EMPTY;
                            end else begin
                                n_state = S_EMIT;
                            end
                        end
                        ulle_pkg::OP_CLEAR: begin
                            n_status = empty ? ulle_pkg::ST_EMPTY : ulle_pkg::ST_OK;
                            n_cnt    = '0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_state = S_DONE;
                if (match[r_j]) begin
                    case (r_op)
                        ulle_pkg::OP_INS_AFTER: begin
                            edit.ins  = 1'b1;
                            edit.pos  = PW'(r_j) + PW'(1);
                            edit.data = r_val;
                            n_cnt     = r_cnt + CW'(1);
                        end
                        ulle_pkg::OP_DEL_VALUE: begin
                            n_res    = rd_val;
                            edit.del = 1'b1;
                            edit.pos = PW'(r_j);
                            n_cnt    = r_cnt - CW'(1);
                        end
                        default: begin
                            n_res = rd_val;
                        end
                    endcase
                end else if (r_j == last_idx) begin
                    n_status = ulle_pkg::ST_NOT_FOUND;
                end else begin
                    n_j     = r_j + IW'(1);
                    n_state = S_SCAN;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = ulle_pkg::ST_OK;
                    n_ovalue  = rd_val;
                    n_olast   = (r_j == last_idx);
                    n_j       = r_j + IW'(1);
                    if (r_j == last_idx) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_ovalue  = r_res;
                    n_olast   = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
        r_op      <= n_op;
        r_val     <= n_val;
        r_key     <= n_key;
        r_j       <= n_j;
        r_status  <= n_status;
        r_res     <= n_res;
        r_ostatus <= n_ostatus;
        r_ovalue  <= n_ovalue;
        r_olast   <= n_olast;
    end

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_ovalid;
    assign o_out.status       = r_ostatus;
    assign o_out.result_value = r_ovalue;
    assign o_out.last         = r_olast;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(CAPACITY))
        else $error("element count beyond capacity");
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT || r_state == S_SCAN) |-> !empty)
        else $error("walk on an empty list");
    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CW'(r_j) < r_cnt))
        else $error("scan index past the list end");
`endif
endmodule

[hdl/ulle_cell.sv]
// one list cell: holds one element and shifts with its neighbors
module ulle_cell #(
    parameter int IDX = 0
) (
    input  logic                                i_clk,
    input  ulle_pkg::t_edit                     i_ctl,
    input  logic signed [ulle_pkg::VAL_W-1:0]   i_left,
    input  logic signed [ulle_pkg::VAL_W-1:0]   i_right,
    input  logic signed [ulle_pkg::VAL_W-1:0]   i_cmp,
    output logic signed [ulle_pkg::VAL_W-1:0]   o_value,
    output logic                                o_match
);
    localparam logic [ulle_pkg::POS_W-1:0] MY_POS = ulle_pkg::POS_W'(IDX);

    logic signed [ulle_pkg::VAL_W-1:0] r_value;
    logic signed [ulle_pkg::VAL_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins) begin
            if (MY_POS > i_ctl.pos) begin
                n_value = i_left;
            end else if (MY_POS == i_ctl.pos) begin
                n_value = i_ctl.data;
            end
        end else if (i_ctl.del && (MY_POS >= i_ctl.pos)) begin
            n_value = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_match = (r_value == i_cmp);
endmodule
